/* design/tvcal_pkg.sv */
// Shared types and constants for the TVC attitude gain-scheduled control law.
// No dependencies; used by the top level and its port checker.
package tvcal_pkg;

  // Configuration register map, word index = paddr[3:2]
  typedef enum logic [1:0] {
    REG_ATT_GAIN   = 2'd0,
    REG_RATE_GAIN  = 2'd1,
    REG_COAST_SCL  = 2'd2,
    REG_PRESS_THR  = 2'd3
  } reg_idx_e;

  localparam int unsigned PaddrW  = 4;
  localparam int unsigned DataW   = 32;
  localparam int unsigned GainW   = 16;
  localparam int unsigned ScaleW  = 13;
  localparam int unsigned PressW  = 20;
  localparam int unsigned CmdW    = 16;
  localparam int unsigned PipeLen = 5;

  localparam logic [GainW-1:0]  AttGainRst  = 16'd2867;
  localparam logic [GainW-1:0]  RateGainRst = 16'd614;
  localparam logic [ScaleW-1:0] CoastSclRst = 13'd2048;
  localparam logic [PressW-1:0] PressThrRst = 20'd100;

  // Unity scale in Q1.12: lets the unscaled path share the coast multiplier
  localparam logic [ScaleW-1:0] ScaleOne = 13'd4096;

  typedef enum logic [1:0] {
    PHASE_LAUNCH  = 2'd0,
    PHASE_GTURN   = 2'd1,
    PHASE_DESCENT = 2'd2,
    PHASE_COAST   = 2'd3
  } phase_e;

  localparam logic signed [CmdW-1:0] CmdMax = 16'sh7FFF;
  localparam logic signed [CmdW-1:0] CmdMin = 16'sh8000;

endpackage

/* design/tvc_attitude_gain_scheduled_law_unit.sv */
// Top level of the TVC attitude gain-scheduled PD law: APB register file and
// a five-stage multiply pipeline. Depends on tvcal_pkg.
//
// Usage:
//   Command channel: drive the quaternion, body rates, dynamic pressure and
//   flight phase and pulse start. busy is never raised, so a transaction
//   is taken on every cycle that start is high.
//   Result channel: done_o is high for one cycle with pitch_cmd_o, yaw_cmd_o
//   and saturated_o valid. Throughput is one item per cycle, set by the fully
//   pipelined multipliers (quaternion products, gain products, then a
//   two-piece scale product).
//   The receiver cannot stall; results must be taken when done_o is high.
//   Config: APB, registers at byte offsets 0x0 attitude_gain, 0x4 rate_gain,
//   0x8 coast_scale, 0xC pressure_threshold. pready is always high. Write the
//   registers only while no transaction is in flight.
//   Reset (rst_ni low, asynchronous) clears the pipeline valid bits and loads
//   the configuration register defaults; nothing else needs to settle afterward.
module tvc_attitude_gain_scheduled_law_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB config
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tvcal_pkg::PaddrW-1:0]  paddr,
  input  logic [tvcal_pkg::DataW-1:0]   pwdata,
  output logic [tvcal_pkg::DataW-1:0]   prdata,
  output logic                          pready,
  // command
  input  logic                          start,
  output logic                          busy,
  input  logic signed [15:0]            quat_w_i,
  input  logic signed [15:0]            quat_x_i,
  input  logic signed [15:0]            quat_y_i,
  input  logic signed [15:0]            quat_z_i,
  input  logic signed [15:0]            pitch_rate_i,
  input  logic signed [15:0]            yaw_rate_i,
  input  logic [19:0]                   dyn_pressure_i,
  input  logic [1:0]                    flight_phase_i,
  // result
  output logic                          done_o,
  output logic signed [15:0]            pitch_cmd_o,
  output logic signed [15:0]            yaw_cmd_o,
  output logic                          saturated_o
);

  // ---------------- register file ----------------
  logic [tvcal_pkg::GainW-1:0]  att_gain_q, rate_gain_q;
  logic [tvcal_pkg::ScaleW-1:0] coast_scl_q;
  logic [tvcal_pkg::PressW-1:0] press_thr_q;
  logic                         wr_en;
  tvcal_pkg::reg_idx_e          reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = tvcal_pkg::reg_idx_e'(paddr[3:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      att_gain_q  <= tvcal_pkg::AttGainRst;
      rate_gain_q <= tvcal_pkg::RateGainRst;
      coast_scl_q <= tvcal_pkg::CoastSclRst;
      press_thr_q <= tvcal_pkg::PressThrRst;
    end else if (wr_en) begin
      case (reg_idx)
        tvcal_pkg::REG_ATT_GAIN:  att_gain_q  <= pwdata[tvcal_pkg::GainW-1:0];
        tvcal_pkg::REG_RATE_GAIN: rate_gain_q <= pwdata[tvcal_pkg::GainW-1:0];
        tvcal_pkg::REG_COAST_SCL: coast_scl_q <= pwdata[tvcal_pkg::ScaleW-1:0];
        tvcal_pkg::REG_PRESS_THR: press_thr_q <= pwdata[tvcal_pkg::PressW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      tvcal_pkg::REG_ATT_GAIN:  prdata = {16'd0, att_gain_q};
      tvcal_pkg::REG_RATE_GAIN: prdata = {16'd0, rate_gain_q};
      tvcal_pkg::REG_COAST_SCL: prdata = {19'd0, coast_scl_q};
      tvcal_pkg::REG_PRESS_THR: prdata = {12'd0, press_thr_q};
      default:                  prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic                            accept;
  logic [tvcal_pkg::PipeLen-1:0]   vld_q, vld_d;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign vld_d  = {vld_q[tvcal_pkg::PipeLen-2:0], accept};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) vld_q <= '0;
    else         vld_q <= vld_d;
  end

  assign done_o = vld_q[tvcal_pkg::PipeLen-1];

  // ---------------- stage 1: quaternion and rate products ----------------
  logic signed [31:0] xz_q, wy_q, xy_q, wz_q;
  logic signed [32:0] krp_q, kry_q;
  logic [tvcal_pkg::ScaleW-1:0] scl1_q;
  logic signed [16:0] kr_s;
  logic               coast_hit;

  assign kr_s      = $signed({1'b0, rate_gain_q});
  assign coast_hit = (dyn_pressure_i >= press_thr_q) &&
                     (flight_phase_i == tvcal_pkg::PHASE_COAST);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      xz_q   <= quat_x_i * quat_z_i;
      wy_q   <= quat_w_i * quat_y_i;
      xy_q   <= quat_x_i * quat_y_i;
      wz_q   <= quat_w_i * quat_z_i;
      krp_q  <= kr_s * pitch_rate_i;
      kry_q  <= kr_s * yaw_rate_i;
      scl1_q <= coast_hit ? coast_scl_q : tvcal_pkg::ScaleOne;
    end
  end

  // ---------------- stage 2: pointing error times Ka ----------------
  logic signed [32:0] diff_y, sum_z;
  logic signed [33:0] err_y, err_z;
  logic signed [16:0] ka_s;
  logic signed [50:0] kae_y_q, kae_z_q;
  logic signed [32:0] krp2_q, kry2_q;
  logic [tvcal_pkg::ScaleW-1:0] scl2_q;

  assign ka_s   = $signed({1'b0, att_gain_q});
  assign diff_y = $signed({xz_q[31], xz_q}) - $signed({wy_q[31], wy_q});
  assign sum_z  = $signed({xy_q[31], xy_q}) + $signed({wz_q[31], wz_q});
  assign err_y  = $signed({diff_y, 1'b0});
  assign err_z  = -$signed({sum_z, 1'b0});

  always_ff @(posedge clk_i) begin
    if (vld_q[0]) begin
      kae_y_q <= ka_s * err_y;
      kae_z_q <= ka_s * err_z;
      krp2_q  <= krp_q;
      kry2_q  <= kry_q;
      scl2_q  <= scl1_q;
    end
  end

  // ---------------- stage 3: PD sum at scale 2^40 ----------------
  logic signed [50:0] acc_p_q, acc_y_q;
  logic [tvcal_pkg::ScaleW-1:0] scl3_q;

  always_ff @(posedge clk_i) begin
    if (vld_q[1]) begin
      acc_p_q <= kae_y_q + $signed({krp2_q[32], krp2_q, 17'd0});
      acc_y_q <= kae_z_q + $signed({kry2_q[32], kry2_q, 17'd0});
      scl3_q  <= scl2_q;
    end
  end

  // ---------------- stage 4: scale, split into two partial products ----------
  // Low part carries the rounding half of the final 2^41 shift.
  localparam logic [40:0] RoundHalf = 41'h100_0000_0000;
  logic [40:0]        lo_p_q, lo_y_q;
  logic signed [38:0] hi_p_q, hi_y_q;
  logic signed [13:0] scl_s;

  assign scl_s = $signed({1'b0, scl3_q});

  always_ff @(posedge clk_i) begin
    if (vld_q[2]) begin
      lo_p_q <= 41'(acc_p_q[25:0] * scl3_q) + RoundHalf;
      lo_y_q <= 41'(acc_y_q[25:0] * scl3_q) + RoundHalf;
      hi_p_q <= $signed(acc_p_q[50:26]) * scl_s;
      hi_y_q <= $signed(acc_y_q[50:26]) * scl_s;
    end
  end

  // ---------------- stage 5: recombine, round, saturate ----------------
  logic signed [65:0] tot_p, tot_y;
  logic signed [24:0] rnd_p, rnd_y;
  logic               ovf_p, ovf_y;
  logic signed [15:0] cmd_p, cmd_y;

  assign tot_p = $signed({{1{hi_p_q[38]}}, hi_p_q, 26'd0}) + $signed({25'd0, lo_p_q});
  assign tot_y = $signed({{1{hi_y_q[38]}}, hi_y_q, 26'd0}) + $signed({25'd0, lo_y_q});
  assign rnd_p = tot_p[65:41];
  assign rnd_y = tot_y[65:41];
  // out of Q4.11 range when the bits above bit 15 are not a sign extension
  assign ovf_p = (rnd_p[24:15] != {10{rnd_p[24]}});
  assign ovf_y = (rnd_y[24:15] != {10{rnd_y[24]}});

  always_comb begin
    if (!ovf_p)          cmd_p = rnd_p[15:0];
    else if (rnd_p[24])  cmd_p = tvcal_pkg::CmdMin;
    else                 cmd_p = tvcal_pkg::CmdMax;
    if (!ovf_y)          cmd_y = rnd_y[15:0];
    else if (rnd_y[24])  cmd_y = tvcal_pkg::CmdMin;
    else                 cmd_y = tvcal_pkg::CmdMax;
  end

  always_ff @(posedge clk_i) begin
    if (vld_q[3]) begin
      pitch_cmd_o <= cmd_p;
      yaw_cmd_o   <= cmd_y;
      saturated_o <= ovf_p || ovf_y;
    end
  end

endmodule

/* design/tvcal_chk.sv */
// Port-level checker for the TVC attitude law unit, bound to the top level.
// Depends on tvcal_pkg and tvc_attitude_gain_scheduled_law_unit.
module tvcal_chk (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          psel,
  input logic                          penable,
  input logic                          pwrite,
  input logic [tvcal_pkg::PaddrW-1:0]  paddr,
  input logic [tvcal_pkg::DataW-1:0]   pwdata,
  input logic [tvcal_pkg::DataW-1:0]   prdata,
  input logic                          pready,
  input logic                          start,
  input logic                          busy,
  input logic                          done_o,
  input logic signed [15:0]            pitch_cmd_o,
  input logic signed [15:0]            yaw_cmd_o,
  input logic                          saturated_o
);

  // every accepted transaction yields a result on done_o
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##5 done_o)
    else $error("accepted transaction produced no result");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(start && !busy) |-> ##5 !done_o)
    else $error("result without an accepted transaction");

  // a saturated result must sit on a rail
  a_sat_rail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && saturated_o) |->
      (pitch_cmd_o == tvcal_pkg::CmdMax || pitch_cmd_o == tvcal_pkg::CmdMin ||
       yaw_cmd_o == tvcal_pkg::CmdMax || yaw_cmd_o == tvcal_pkg::CmdMin))
    else $error("saturation flagged with no command at a limit");

  // an attitude gain write reads back on the next cycle at the same address
  a_readback: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (psel && penable && pwrite && pready && paddr[3:2] == tvcal_pkg::REG_ATT_GAIN) ##1
      (paddr[3:2] == tvcal_pkg::REG_ATT_GAIN) |->
      (prdata[15:0] == $past(pwdata[15:0])))
    else $error("attitude gain readback mismatch");

endmodule

bind tvc_attitude_gain_scheduled_law_unit tvcal_chk u_tvcal_chk (.*);
